// ----- src/rv32_pkg.sv -----
package rv32_pkg;

   localparam int MEM_BYTES_DEF = 65536;

   localparam int IN_BITS = 56;
   localparam int OUT_BITS = 72;

   localparam logic [6:0] OPC_OP = 7'h33;
   localparam logic [6:0] OPC_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD = 7'h03;
   localparam logic [6:0] OPC_STORE = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL = 7'h6F;
   localparam logic [6:0] OPC_JALR = 7'h67;
   localparam logic [6:0] OPC_LUI = 7'h37;
   localparam logic [6:0] OPC_AUIPC = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

   localparam logic [2:0] ST_EXEC = 3'd0;
   localparam logic [2:0] ST_UNKNOWN = 3'd1;
   localparam logic [2:0] ST_EXIT = 3'd2;
   localparam logic [2:0] ST_PRINT = 3'd3;
   localparam logic [2:0] ST_EBREAK = 3'd4;
   localparam logic [2:0] ST_IGNORED = 3'd5;
   localparam logic [2:0] ST_WRITTEN = 3'd6;

   localparam logic [0:0] REQ_WRITE = 1'b0;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_FETCH, S_REGA, S_REGB, S_EXEC, S_LOAD, S_STORE, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      CLS_OP, CLS_IMM, CLS_LOAD, CLS_STORE, CLS_BRANCH, CLS_JAL, CLS_JALR,
      CLS_LUI, CLS_AUIPC, CLS_SYSTEM, CLS_UNKNOWN
   } class_type;

   typedef enum logic [1:0] {
      BASE_WORD, BASE_PC, BASE_EA
   } base_type;

   typedef enum logic [1:0] {
      SEL_RS1, SEL_A7, SEL_SECOND
   } rsel_type;

   typedef struct packed {
      logic clr;
      logic cap_req;
      logic mem_rd;
      logic mem_wr;
      base_type mem_base;
      logic [1:0] idx;
      logic cap_inst;
      logic cap_load;
      logic [1:0] cap_idx;
      rsel_type rf_sel;
      logic cap_a;
      logic cap_b;
      logic finish;
   } cmd_type;

   typedef struct packed {
      class_type cls;
      logic [2:0] nbytes;
      logic halted;
      logic clr_last;
      logic rsp_busy;
   } stat_type;

   function automatic class_type decode(input logic [6:0] op);
      class_type c;
      case (op)
         OPC_OP: c = CLS_OP;
         OPC_IMM: c = CLS_IMM;
         OPC_LOAD: c = CLS_LOAD;
         OPC_STORE: c = CLS_STORE;
         OPC_BRANCH: c = CLS_BRANCH;
         OPC_JAL: c = CLS_JAL;
         OPC_JALR: c = CLS_JALR;
         OPC_LUI: c = CLS_LUI;
         OPC_AUIPC: c = CLS_AUIPC;
         OPC_SYSTEM: c = CLS_SYSTEM;
         default: c = CLS_UNKNOWN;
      endcase
      return c;
   endfunction

endpackage

// ----- src/rv32_ctrl.sv -----
module rv32_ctrl
   import rv32_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_write,
   output logic req_tready,
   input  stat_type st,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 3'd1;
      req_tready = 1'b0;
      cmd = '0;
      cmd.mem_base = BASE_PC;
      cmd.rf_sel = SEL_RS1;
      cmd.idx = cnt_ff[1:0];
      cmd.cap_idx = cnt_ff[1:0] - 2'd1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            cnt_in = 3'd0;
            if (req_tvalid) begin
               cmd.cap_req = 1'b1;
               if (req_write == REQ_WRITE) state_in = S_WRITE;
               else if (st.halted) state_in = S_RESP;
               else state_in = S_FETCH;
            end
         end
         S_WRITE: begin
            cmd.mem_wr = 1'b1;
            cmd.mem_base = BASE_WORD;
            if (cnt_ff == 3'd3) state_in = S_RESP;
         end
         S_FETCH: begin
            cmd.mem_rd = (cnt_ff != 3'd4);
            cmd.cap_inst = (cnt_ff != 3'd0);
            if (cnt_ff == 3'd4) state_in = S_REGA;
         end
         S_REGA: begin
            cmd.rf_sel = (st.cls == CLS_SYSTEM) ? SEL_A7 : SEL_RS1;
            state_in = S_REGB;
         end
         S_REGB: begin
            cmd.cap_a = 1'b1;
            cmd.rf_sel = SEL_SECOND;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.cap_b = 1'b1;
            cnt_in = 3'd0;
            if (st.cls == CLS_LOAD && st.nbytes != 3'd0) state_in = S_LOAD;
            else if (st.cls == CLS_STORE && st.nbytes != 3'd0) state_in = S_STORE;
            else state_in = S_RESP;
         end
         S_LOAD: begin
            cmd.mem_base = BASE_EA;
            cmd.mem_rd = (cnt_ff != st.nbytes);
            cmd.cap_load = (cnt_ff != 3'd0);
            if (cnt_ff == st.nbytes) state_in = S_RESP;
         end
         S_STORE: begin
            cmd.mem_base = BASE_EA;
            cmd.mem_wr = 1'b1;
            if (cnt_ff == st.nbytes - 3'd1) state_in = S_RESP;
         end
         S_RESP: begin
            if (!st.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- src/rv32_dpath.sv -----
module rv32_dpath
   import rv32_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [IN_BITS-1:0] req_tdata,
   input  logic rsp_tready,
   output logic rsp_tvalid,
   output logic [OUT_BITS-1:0] rsp_tdata,
   input  cmd_type cmd,
   output stat_type st
);

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] mem_q_ff;
   logic [31:0] rf [32];
   logic [31:0] rf_valid_ff;
   logic [31:0] rf_q_ff;

   logic [AW-1:0] clr_ff;
   logic req_op_ff;
   logic [15:0] req_addr_ff;
   logic [31:0] req_word_ff;
   logic [31:0] inst_ff, load_ff, a_ff, b_ff, pc_ff;
   logic halted_ff;
   logic rsp_valid_ff;
   logic [OUT_BITS-1:0] rsp_data_ff;

   class_type cls;
   logic [6:0] f7;
   logic [2:0] f3;
   logic [4:0] rd, rs1, rs2, rf_idx;
   logic [31:0] immi, imms, immb, immj, ea, word_addr, wdata_word;
   logic [AW-1:0] maddr;
   logic [7:0] mwdata;
   logic [4:0] sh;
   logic [31:0] opb, res, next_pc, report, lval;
   logic we, take, is_exit, is_print, is_brk, lt_s, lt_u;
   logic [2:0] status;
   logic [2:0] nbytes;

   assign f7 = inst_ff[31:25];
   assign f3 = inst_ff[14:12];
   assign rd = inst_ff[11:7];
   assign rs1 = inst_ff[19:15];
   assign rs2 = inst_ff[24:20];
   assign cls = decode(inst_ff[6:0]);
   assign immi = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign imms = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign immb = {{19{inst_ff[31]}}, inst_ff[31], inst_ff[7], inst_ff[30:25],
                  inst_ff[11:8], 1'b0};
   assign immj = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
                  inst_ff[30:21], 1'b0};
   assign ea = a_ff + ((cls == CLS_STORE) ? imms : immi);
   assign word_addr = {16'h0, req_addr_ff};

   always_comb begin
      case (cmd.mem_base)
         BASE_WORD: maddr = word_addr[AW-1:0];
         BASE_EA: maddr = ea[AW-1:0];
         default: maddr = pc_ff[AW-1:0];
      endcase
      maddr = maddr + AW'(cmd.idx);
      wdata_word = (cmd.mem_base == BASE_WORD) ? req_word_ff : b_ff;
      mwdata = wdata_word[8*cmd.idx +: 8];
      if (cmd.clr) begin
         maddr = clr_ff;
         mwdata = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr || cmd.mem_wr) mem[maddr] <= mwdata;
      mem_q_ff <= mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + AW'(1);
   end

   always_comb begin
      case (cmd.rf_sel)
         SEL_A7: rf_idx = 5'd17;
         SEL_SECOND: begin
            if (cls == CLS_SYSTEM) rf_idx = (rf_q_ff == 32'd1) ? 5'd11 : 5'd10;
            else rf_idx = rs2;
         end
         default: rf_idx = rs1;
      endcase
   end

   always_ff @(posedge clock) begin
      rf_q_ff <= rf_valid_ff[rf_idx] ? rf[rf_idx] : 32'h0;
      if (we) rf[rd] <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) rf_valid_ff <= '0;
      else if (we) rf_valid_ff[rd] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         req_op_ff <= req_tdata[0];
         req_addr_ff <= req_tdata[16:1];
         req_word_ff <= req_tdata[48:17];
      end
      if (cmd.cap_inst) inst_ff[8*cmd.cap_idx +: 8] <= mem_q_ff;
      if (cmd.cap_load) load_ff[8*cmd.cap_idx +: 8] <= mem_q_ff;
      if (cmd.cap_a) a_ff <= rf_q_ff;
      if (cmd.cap_b) b_ff <= rf_q_ff;
      if (cmd.finish) begin
         rsp_data_ff <= {4'h0, halted_ff | is_exit | is_brk, report, next_pc, status};
      end
   end

   always_comb begin
      case (f3[1:0])
         2'd0: lval = {{24{load_ff[7] & ~f3[2]}}, load_ff[7:0]};
         2'd1: lval = {{16{load_ff[15] & ~f3[2]}}, load_ff[15:0]};
         default: lval = load_ff;
      endcase
   end

   always_comb begin
      opb = (cls == CLS_OP) ? b_ff : immi;
      sh = (cls == CLS_OP) ? b_ff[4:0] : rs2;
      lt_s = $signed(a_ff) < $signed(opb);
      lt_u = a_ff < opb;
      res = 32'h0;
      we = 1'b0;
      take = 1'b0;
      is_exit = 1'b0;
      is_print = 1'b0;
      is_brk = 1'b0;
      nbytes = 3'd0;
      next_pc = pc_ff + 32'd4;
      case (cls)
         CLS_OP, CLS_IMM: begin
            we = 1'b1;
            case (f3)
               3'd0: begin
                  if (cls == CLS_IMM || f7 == 7'h00) res = a_ff + opb;
                  else if (f7 == 7'h20) res = a_ff - opb;
                  else we = 1'b0;
               end
               3'd1: begin
                  res = a_ff << sh;
                  we = (cls == CLS_OP) || (f7 == 7'h00);
               end
               3'd2: res = {31'h0, lt_s};
               3'd3: res = {31'h0, lt_u};
               3'd4: res = a_ff ^ opb;
               3'd5: begin
                  if (f7 == 7'h00) res = a_ff >> sh;
                  else if (f7 == 7'h20) res = $unsigned($signed(a_ff) >>> sh);
                  else we = 1'b0;
               end
               3'd6: res = a_ff | opb;
               default: res = a_ff & opb;
            endcase
         end
         CLS_LOAD: begin
            res = lval;
            case (f3)
               3'd0, 3'd4: nbytes = 3'd1;
               3'd1, 3'd5: nbytes = 3'd2;
               3'd2: nbytes = 3'd4;
               default: nbytes = 3'd0;
            endcase
            we = (nbytes != 3'd0);
         end
         CLS_STORE: begin
            case (f3)
               3'd0: nbytes = 3'd1;
               3'd1: nbytes = 3'd2;
               3'd2: nbytes = 3'd4;
               default: nbytes = 3'd0;
            endcase
         end
         CLS_BRANCH: begin
            case (f3)
               3'd0: take = a_ff == b_ff;
               3'd1: take = a_ff != b_ff;
               3'd4: take = $signed(a_ff) < $signed(b_ff);
               3'd5: take = !($signed(a_ff) < $signed(b_ff));
               3'd6: take = a_ff < b_ff;
               3'd7: take = a_ff >= b_ff;
               default: take = 1'b0;
            endcase
            if (take) next_pc = pc_ff + immb;
         end
         CLS_JAL: begin
            we = 1'b1;
            res = pc_ff + 32'd4;
            next_pc = pc_ff + immj;
         end
         CLS_JALR: begin
            we = 1'b1;
            res = pc_ff + 32'd4;
            next_pc = (a_ff + immi) & ~32'd1;
         end
         CLS_LUI: begin
            we = 1'b1;
            res = inst_ff & UPPER_MASK;
         end
         CLS_AUIPC: begin
            we = 1'b1;
            res = pc_ff + (inst_ff & UPPER_MASK);
         end
         CLS_SYSTEM: begin
            if (inst_ff[31:20] == 12'd0) begin
               is_exit = (a_ff == 32'd10) || (a_ff == 32'd93);
               is_print = (a_ff == 32'd1);
            end else if (inst_ff[31:20] == 12'd1) begin
               is_brk = 1'b1;
            end
            if (is_exit || is_brk) next_pc = pc_ff;
         end
         default: ;
      endcase
      if (req_op_ff == REQ_WRITE || halted_ff) begin
         we = 1'b0;
         is_exit = 1'b0;
         is_print = 1'b0;
         is_brk = 1'b0;
         next_pc = pc_ff;
      end
      we = we && cmd.finish && (rd != 5'd0);
      report = (is_exit || is_print) ? b_ff : 32'h0;
      if (req_op_ff == REQ_WRITE) status = ST_WRITTEN;
      else if (halted_ff) status = ST_IGNORED;
      else if (cls == CLS_UNKNOWN) status = ST_UNKNOWN;
      else if (is_exit) status = ST_EXIT;
      else if (is_print) status = ST_PRINT;
      else if (is_brk) status = ST_EBREAK;
      else status = ST_EXEC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 32'h0;
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            pc_ff <= next_pc;
            halted_ff <= halted_ff | is_exit | is_brk;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign st.cls = cls;
   assign st.nbytes = nbytes;
   assign st.halted = halted_ff;
   assign st.clr_last = &clr_ff;
   assign st.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ----- src/rv32i_instruction_step.sv -----
// A word write stores its four bytes; an executed instruction passes through fetch,
// two register reads and execute, then reads or writes its load or store bytes; a
// request while halted goes straight to the response.
// The next request is taken in the same cycle as the response is issued; a stalled
// response holds the next response back. Fetch and data share one byte-wide memory port.
// Reset is synchronous; afterwards a clearing pass writes zero to every memory
// byte, one per cycle, before the first request is taken.
module rv32i_instruction_step
   import rv32_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // opcode, load_address, load_word
   input  logic [IN_BITS-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, pc_after, report_value, halted
   output logic [OUT_BITS-1:0] rsp_tdata
);

   cmd_type cmd;
   stat_type st;

   rv32_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_write(req_tdata[0]),
      .req_tready(req_tready),
      .st(st),
      .cmd(cmd)
   );

   rv32_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata(rsp_tdata),
      .cmd(cmd),
      .st(st)
   );

endmodule

// ----- bench/rv32i_instruction_step_checker.sv -----
`timescale 1ns / 1ps

module rv32i_instruction_step_checker
   import rv32_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [IN_BITS-1:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [OUT_BITS-1:0] rsp_tdata,
   output int fail_count,
   output int pending_count,
   output int checked_count,
   output logic [31:0] core_pc
);

   typedef struct packed {
      logic halted;
      logic [31:0] report_value;
      logic [31:0] pc_after;
      logic [2:0] status;
   } step_result_type;

   logic [7:0] byte_store [MEM_BYTES_DEF];
   logic [31:0] gpr [32];
   logic stopped;
   step_result_type awaited_results [$];

   function automatic logic [31:0] fetch_bytes(input logic [31:0] addr, input int n);
      logic [31:0] base;
      logic [31:0] v;
      base = addr % MEM_BYTES_DEF;
      v = 0;
      for (int i = 0; i < n; i++) begin
         v[8*i +: 8] = byte_store[(base + i) % MEM_BYTES_DEF];
      end
      return v;
   endfunction

   task automatic store_bytes(input logic [31:0] addr, input logic [31:0] v, input int n);
      logic [31:0] base;
      base = addr % MEM_BYTES_DEF;
      for (int i = 0; i < n; i++) begin
         byte_store[(base + i) % MEM_BYTES_DEF] = v[8*i +: 8];
      end
   endtask

   task automatic set_gpr(input logic [4:0] r, input logic [31:0] v);
      if (r != 0) begin
         gpr[r] = v;
      end
   endtask

   task automatic step_core(input logic [IN_BITS-1:0] d, output step_result_type res);
      logic [31:0] inst, a, b, immi, ims, imb, imj, ea, next, lv;
      logic [6:0] op, f7;
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic take;
      res = '0;
      res.status = ST_EXEC;
      next = core_pc + 4;
      if (d[0] == REQ_WRITE) begin
         store_bytes({16'h0, d[16:1]}, d[48:17], 4);
         res.status = ST_WRITTEN;
         next = core_pc;
      end else if (stopped) begin
         res.status = ST_IGNORED;
         next = core_pc;
      end else begin
         inst = fetch_bytes(core_pc, 4);
         op = inst[6:0];
         rd = inst[11:7];
         f3 = inst[14:12];
         rs1 = inst[19:15];
         rs2 = inst[24:20];
         f7 = inst[31:25];
         immi = {{20{inst[31]}}, inst[31:20]};
         ims = {{20{inst[31]}}, inst[31:25], inst[11:7]};
         imb = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
         imj = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
         a = gpr[rs1];
         b = gpr[rs2];
         case (op)
            OPC_OP: begin
               case (f3)
                  3'd0: begin
                     if (f7 == 7'h00) set_gpr(rd, a + b);
                     else if (f7 == 7'h20) set_gpr(rd, a - b);
                  end
                  3'd1: set_gpr(rd, a << b[4:0]);
                  3'd2: set_gpr(rd, {31'h0, $signed(a) < $signed(b)});
                  3'd3: set_gpr(rd, {31'h0, a < b});
                  3'd4: set_gpr(rd, a ^ b);
                  3'd5: begin
                     if (f7 == 7'h00) set_gpr(rd, a >> b[4:0]);
                     else if (f7 == 7'h20) set_gpr(rd, $signed(a) >>> b[4:0]);
                  end
                  3'd6: set_gpr(rd, a | b);
                  default: set_gpr(rd, a & b);
               endcase
            end
            OPC_IMM: begin
               case (f3)
                  3'd0: set_gpr(rd, a + immi);
                  3'd1: if (f7 == 7'h00) set_gpr(rd, a << rs2);
                  3'd2: set_gpr(rd, {31'h0, $signed(a) < $signed(immi)});
                  3'd3: set_gpr(rd, {31'h0, a < immi});
                  3'd4: set_gpr(rd, a ^ immi);
                  3'd5: begin
                     if (f7 == 7'h00) set_gpr(rd, a >> rs2);
                     else if (f7 == 7'h20) set_gpr(rd, $signed(a) >>> rs2);
                  end
                  3'd6: set_gpr(rd, a | immi);
                  default: set_gpr(rd, a & immi);
               endcase
            end
            OPC_LOAD: begin
               ea = a + immi;
               case (f3)
                  3'd0: begin
                     lv = fetch_bytes(ea, 1);
                     set_gpr(rd, {{24{lv[7]}}, lv[7:0]});
                  end
                  3'd1: begin
                     lv = fetch_bytes(ea, 2);
                     set_gpr(rd, {{16{lv[15]}}, lv[15:0]});
                  end
                  3'd2: set_gpr(rd, fetch_bytes(ea, 4));
                  3'd4: set_gpr(rd, fetch_bytes(ea, 1));
                  3'd5: set_gpr(rd, fetch_bytes(ea, 2));
                  default: ;
               endcase
            end
            OPC_STORE: begin
               ea = a + ims;
               if (f3 == 3'd0) store_bytes(ea, b, 1);
               else if (f3 == 3'd1) store_bytes(ea, b, 2);
               else if (f3 == 3'd2) store_bytes(ea, b, 4);
            end
            OPC_BRANCH: begin
               case (f3)
                  3'd0: take = a == b;
                  3'd1: take = a != b;
                  3'd4: take = $signed(a) < $signed(b);
                  3'd5: take = $signed(a) >= $signed(b);
                  3'd6: take = a < b;
                  3'd7: take = a >= b;
                  default: take = 1'b0;
               endcase
               if (take) next = core_pc + imb;
            end
            OPC_JAL: begin
               set_gpr(rd, core_pc + 4);
               next = core_pc + imj;
            end
            OPC_JALR: begin
               set_gpr(rd, core_pc + 4);
               next = (a + immi) & ~32'h1;
            end
            OPC_LUI: set_gpr(rd, inst & UPPER_MASK);
            OPC_AUIPC: set_gpr(rd, core_pc + (inst & UPPER_MASK));
            OPC_SYSTEM: begin
               if (inst[31:20] == 12'd0) begin
                  if (gpr[17] == 32'd10 || gpr[17] == 32'd93) begin
                     res.status = ST_EXIT;
                     res.report_value = gpr[10];
                     stopped = 1'b1;
                     next = core_pc;
                  end else if (gpr[17] == 32'd1) begin
                     res.status = ST_PRINT;
                     res.report_value = gpr[11];
                  end
               end else if (inst[31:20] == 12'd1) begin
                  res.status = ST_EBREAK;
                  stopped = 1'b1;
                  next = core_pc;
               end
            end
            default: res.status = ST_UNKNOWN;
         endcase
      end
      core_pc = next;
      res.pc_after = core_pc;
      res.halted = stopped;
   endtask

   always @(posedge clock) begin
      step_result_type want, got;
      if (reset) begin
         for (int i = 0; i < MEM_BYTES_DEF; i++) byte_store[i] = 8'h0;
         for (int i = 0; i < 32; i++) gpr[i] = 32'h0;
         stopped = 1'b0;
         core_pc = 32'h0;
         fail_count = 0;
         checked_count = 0;
         awaited_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            step_core(req_tdata, want);
            awaited_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[67:0];
            checked_count++;
            if (awaited_results.size() == 0) begin
               if (fail_count < 10) $display("Unexpected response %h", got);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("Mismatch: status %0d/%0d pc %h/%h report %h/%h halted %b/%b",
                              want.status, got.status, want.pc_after, got.pc_after,
                              want.report_value, got.report_value, want.halted, got.halted);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

// ----- bench/rv32i_instruction_step_tb.sv -----
`timescale 1ns / 1ps

module rv32i_instruction_step_tb;
   import rv32_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_BITS-1:0] rsp_tdata;
   int fail_count, pending_count, checked_count;
   logic [31:0] core_pc;
   int phase = 0;
   int sent_count = 0;

   rv32i_instruction_step u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   rv32i_instruction_step_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .checked_count(checked_count), .core_pc(core_pc)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   always @(negedge clock) begin
      if (phase == 2) rsp_tready <= $urandom_range(99) >= 64;
      else if (phase == 3) rsp_tready <= $urandom_range(99) >= 7;
      else rsp_tready <= 1'b1;
   end

   function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_OP};
   endfunction

   function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
         input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] s_type(input logic [11:0] imm, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] b_type(input logic [12:0] imm, input logic [4:0] rs2,
         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] j_type(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   task automatic send(input logic op, input logic [15:0] addr, input logic [31:0] word);
      logic taken;
      while ((phase == 1 && $urandom_range(99) < 64) || (phase == 3 && $urandom_range(99) < 7))
      begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'h0, word, addr, op};
      do begin
         taken = req_tready;
         @(negedge clock);
      end while (!taken);
      sent_count++;
   endtask

   task automatic run_inst(input logic [31:0] inst);
      send(REQ_WRITE, core_pc[15:0], inst);
      send(~REQ_WRITE, 16'h0, 32'h0);
   endtask

   function automatic logic [31:0] random_inst();
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [6:0] f7, op;
      rd = $urandom;
      rs1 = $urandom;
      rs2 = $urandom;
      f3 = $urandom;
      f7 = ($urandom_range(3) == 0) ? 7'($urandom) : ($urandom_range(1) ? 7'h20 : 7'h00);
      case ($urandom_range(11))
         0, 1: return r_type(f7, rs2, rs1, f3, rd);
         2, 3: begin
            if (f3 == 3'd1 || f3 == 3'd5) return {f7, rs2, rs1, f3, rd, OPC_IMM};
            return i_type(12'($urandom), rs1, f3, rd, OPC_IMM);
         end
         4: return i_type(12'($urandom), rs1, f3, rd, OPC_LOAD);
         5: return s_type(12'($urandom), rs2, rs1, f3);
         6: return b_type(13'($urandom), rs2, rs1, f3);
         7: return j_type(21'($urandom), rd);
         8: return i_type(12'($urandom), rs1, f3, rd, OPC_JALR);
         9: return {20'($urandom), rd, $urandom_range(1) ? OPC_LUI : OPC_AUIPC};
         10: return i_type(12'($urandom_range(4095, 2)), rs1, f3, rd, OPC_SYSTEM);
         default: begin
            do op = $urandom; while (op == OPC_OP || op == OPC_IMM || op == OPC_LOAD ||
               op == OPC_STORE || op == OPC_BRANCH || op == OPC_JAL || op == OPC_JALR ||
               op == OPC_LUI || op == OPC_AUIPC || op == OPC_SYSTEM);
            return {25'($urandom), op};
         end
      endcase
   endfunction

   initial begin
      int v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(REQ_WRITE, 16'hFFFF, 32'hFFFFFFFF);
      send(~REQ_WRITE, 16'h0, 32'h0);
      run_inst(i_type(12'hFFF, 5'd0, 3'd0, 5'd1, OPC_IMM));
      run_inst({20'hFFFFF, 5'd2, OPC_LUI});
      run_inst(i_type(12'd33, 5'd0, 3'd0, 5'd3, OPC_IMM));
      run_inst(r_type(7'h00, 5'd3, 5'd1, 3'd1, 5'd4));
      run_inst(r_type(7'h20, 5'd3, 5'd2, 3'd5, 5'd5));
      run_inst(r_type(7'h20, 5'd1, 5'd3, 3'd0, 5'd6));
      run_inst(r_type(7'h00, 5'd1, 5'd3, 3'd3, 5'd0));
      run_inst(i_type(12'hFFE, 5'd0, 3'd0, 5'd7, OPC_IMM));
      run_inst(s_type(12'd0, 5'd2, 5'd7, 3'd2));
      run_inst(i_type(12'd0, 5'd7, 3'd2, 5'd8, OPC_LOAD));
      run_inst(i_type(12'd1, 5'd7, 3'd0, 5'd9, OPC_LOAD));
      run_inst(i_type(12'd2, 5'd7, 3'd5, 5'd10, OPC_LOAD));
      run_inst(i_type(12'd1, 5'd0, 3'd0, 5'd17, OPC_IMM));
      run_inst(i_type(12'h7FF, 5'd0, 3'd0, 5'd11, OPC_IMM));
      run_inst(i_type(12'd0, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
      run_inst(i_type(12'd4, 5'd0, 3'd0, 5'd17, OPC_IMM));
      run_inst(i_type(12'd0, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
      run_inst(i_type(12'd2, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
      run_inst(32'h0000007F);

      while (sent_count < 1300) begin
         phase = (sent_count / 100) % 4;
         v = $urandom_range(99);
         if (v < 6) begin
            send(REQ_WRITE, 16'($urandom), $urandom);
         end else if (v < 9) begin
            send(~REQ_WRITE, 16'h0, 32'h0);
         end else if (v < 17) begin
            run_inst(i_type(12'($urandom_range(4) == 0 ? 1 : $urandom_range(9)), 5'd0, 3'd0,
                            5'd17, OPC_IMM));
            run_inst(i_type(12'd0, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
         end else begin
            run_inst(random_inst());
         end
      end

      if ($urandom_range(1)) begin
         run_inst(i_type(12'($urandom_range(1) ? 93 : 10), 5'd0, 3'd0, 5'd17, OPC_IMM));
         run_inst(i_type(12'd0, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
      end else begin
         run_inst(i_type(12'd1, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
      end
      run_inst(random_inst());
      send(~REQ_WRITE, 16'h0, 32'h0);
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      $display("Sent %0d requests covering all instruction classes, halting and idle phases.",
               sent_count);
      $display("Checked %0d responses, %0d mismatches.", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
